FILE: rtl/bqf_pkg.sv
package bqf_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;

  localparam int COEF_BITS    = 32;
  localparam int DELAY_BITS   = 48;
  localparam int DELAY_FRAC   = 39;
  localparam int ACC_BITS     = 64;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_FF_GAIN0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FF_GAIN1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FF_GAIN2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FB_GAIN1 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FB_GAIN2 = 3'd4;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] ff_gain0;
    logic signed [COEF_BITS-1:0] ff_gain1;
    logic signed [COEF_BITS-1:0] ff_gain2;
    logic signed [COEF_BITS-1:0] fb_gain1;
    logic signed [COEF_BITS-1:0] fb_gain2;
  } coef_t;

endpackage

FILE: rtl/biquad_iir_filter_top.sv
// Channel   Handshake                  Payload
// cfg       cfg_we_i                   cfg_idx_i, cfg_wdata_i
// in        in_valid_i / in_stall_o    sample_in_i
// out       out_valid_o / out_stall_i  sample_out_o, clipped_o
//
// A sample is taken at the accepting edge and then runs through seven sequencer steps.
// The single shared multiplier forms the five coefficient products one per step.
// Reset sets ff_gain0 to 1.0, the other gains and both delays to zero.
// A new sample is taken while a finished beat waits in the output register.
// The last step holds while that register is full and stalled.
module biquad_iir_filter_top #(
  parameter int SAMPLE_BITS    = bqf_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bqf_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bqf_pkg::COEF_BITS-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o,
  output logic                              clipped_o
);

  localparam int CB    = bqf_pkg::COEF_BITS;
  localparam int AW    = bqf_pkg::ACC_BITS;
  localparam int DW    = bqf_pkg::DELAY_BITS;
  localparam int DF    = bqf_pkg::DELAY_FRAC;
  localparam int PW    = SAMPLE_BITS + CB;
  localparam int PFRAC = SAMPLE_BITS - 1 + COEF_FRAC_BITS;
  localparam int RSH   = (PFRAC >= DF) ? PFRAC - DF : 0;
  localparam int LSH   = (PFRAC < DF) ? DF - PFRAC : 0;
  localparam int OSH   = DF - (SAMPLE_BITS - 1);

  localparam logic signed [AW-1:0] P_HALF = (AW'(1) << RSH) >> 1;
  localparam logic signed [AW-1:0] O_HALF = AW'(1) << (OSH - 1);
  localparam logic signed [AW-1:0] S_MAX  = (AW'(1) << (SAMPLE_BITS - 1)) - AW'(1);
  localparam logic signed [AW-1:0] S_MIN  = -S_MAX - AW'(1);
  localparam logic signed [AW-1:0] D_MAX  = (AW'(1) << (DW - 1)) - AW'(1);
  localparam logic signed [AW-1:0] D_MIN  = -D_MAX - AW'(1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL0 = 3'd1;
  localparam logic [2:0] ST_ACC0 = 3'd2;
  localparam logic [2:0] ST_YOUT = 3'd3;
  localparam logic [2:0] ST_FB1  = 3'd4;
  localparam logic [2:0] ST_FB2  = 3'd5;
  localparam logic [2:0] ST_N2   = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  bqf_pkg::coef_t coef;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, clip_q;
  logic       in_acc, out_acc, done_go;

  logic signed [SAMPLE_BITS-1:0] x_q, y_q, y_sat, mul_a, out_q;
  logic signed [CB-1:0]          mul_b;
  logic signed [PW-1:0]          mul_p, prod_q;
  logic signed [AW-1:0]          td, add_a, add_sum, acc_q, n1_q, y_rnd, d1_ext, d2_ext;
  logic signed [DW-1:0]          d1_q, d2_q, d1_new, d2_new;
  logic                          add_sub, y_clip, d1_clip, d2_clip, out_clip_q;

  bqf_cfg #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .coef_o     (coef)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign done_go    = !out_valid_q || !out_stall_i;

  always_comb begin
    mul_a   = x_q;
    mul_b   = '0;
    add_a   = '0;
    add_sub = 1'b0;
    case (state_q)
      ST_MUL0: begin
        mul_b = coef.ff_gain0;
      end
      ST_ACC0: begin
        mul_b = coef.ff_gain1;
        add_a = d1_ext;
      end
      ST_YOUT: begin
        mul_b = coef.ff_gain2;
        add_a = d2_ext;
      end
      ST_FB1: begin
        mul_a = y_q;
        mul_b = coef.fb_gain1;
      end
      ST_FB2: begin
        mul_a   = y_q;
        mul_b   = coef.fb_gain2;
        add_a   = n1_q;
        add_sub = 1'b1;
      end
      ST_N2: begin
        add_a   = acc_q;
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mul_p   = PW'(mul_a) * PW'(mul_b);
  assign td      = ((AW'(prod_q) + P_HALF) >>> RSH) <<< LSH;
  assign add_sum = add_sub ? (add_a - td) : (add_a + td);
  assign d1_ext  = AW'(d1_q);
  assign d2_ext  = AW'(d2_q);

  always_comb begin
    y_rnd  = (acc_q + O_HALF) >>> OSH;
    y_clip = 1'b0;
    if (y_rnd > S_MAX) begin
      y_sat  = SAMPLE_BITS'(S_MAX);
      y_clip = 1'b1;
    end else if (y_rnd < S_MIN) begin
      y_sat  = SAMPLE_BITS'(S_MIN);
      y_clip = 1'b1;
    end else begin
      y_sat = SAMPLE_BITS'(y_rnd);
    end
  end

  always_comb begin
    d1_clip = 1'b0;
    d2_clip = 1'b0;
    if (n1_q > D_MAX) begin
      d1_new  = DW'(D_MAX);
      d1_clip = 1'b1;
    end else if (n1_q < D_MIN) begin
      d1_new  = DW'(D_MIN);
      d1_clip = 1'b1;
    end else begin
      d1_new = DW'(n1_q);
    end
    if (acc_q > D_MAX) begin
      d2_new  = DW'(D_MAX);
      d2_clip = 1'b1;
    end else if (acc_q < D_MIN) begin
      d2_new  = DW'(D_MIN);
      d2_clip = 1'b1;
    end else begin
      d2_new = DW'(acc_q);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_MUL0;
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = state_q + 3'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      clip_q      <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        clip_q <= 1'b0;
      end else if (state_q == ST_YOUT) begin
        clip_q <= clip_q | y_clip;
      end
      if (state_q == ST_DONE && done_go) begin
        d1_q        <= d1_new;
        d2_q        <= d2_new;
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= sample_in_i;
    end
    prod_q <= mul_p;
    case (state_q)
      ST_ACC0: begin
        acc_q <= add_sum;
      end
      ST_YOUT: begin
        y_q   <= y_sat;
        acc_q <= add_sum;
      end
      ST_FB1: begin
        n1_q  <= acc_q;
        acc_q <= add_sum;
      end
      ST_FB2: begin
        n1_q <= add_sum;
      end
      ST_N2: begin
        acc_q <= add_sum;
      end
      ST_DONE: begin
        if (done_go) begin
          out_q      <= y_q;
          out_clip_q <= clip_q | d1_clip | d2_clip;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;
  assign clipped_o    = out_clip_q;

endmodule

FILE: rtl/bqf_cfg.sv
module bqf_cfg #(
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bqf_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bqf_pkg::COEF_BITS-1:0]     cfg_wdata_i,
  output bqf_pkg::coef_t                    coef_o
);

  localparam int CB = bqf_pkg::COEF_BITS;
  localparam logic signed [CB-1:0] FF0_RST = CB'(1) << COEF_FRAC_BITS;

  bqf_pkg::coef_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.ff_gain0 <= FF0_RST;
      coef_q.ff_gain1 <= '0;
      coef_q.ff_gain2 <= '0;
      coef_q.fb_gain1 <= '0;
      coef_q.fb_gain2 <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bqf_pkg::REG_FF_GAIN0: begin
          coef_q.ff_gain0 <= cfg_wdata_i;
        end
        bqf_pkg::REG_FF_GAIN1: begin
          coef_q.ff_gain1 <= cfg_wdata_i;
        end
        bqf_pkg::REG_FF_GAIN2: begin
          coef_q.ff_gain2 <= cfg_wdata_i;
        end
        bqf_pkg::REG_FB_GAIN1: begin
          coef_q.fb_gain1 <= cfg_wdata_i;
        end
        bqf_pkg::REG_FB_GAIN2: begin
          coef_q.fb_gain2 <= cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

FILE: rtl/bqf_chk.sv
module bqf_chk #(
  parameter int SAMPLE_BITS = bqf_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_i,
  input logic                          out_valid_i,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] sample_out_i,
  input logic                          clipped_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(sample_out_i) && $stable(clipped_i))
    else $error("output beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input taken again right after a beat");

  a_busy_full_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |-> ##6 in_stall_i)
    else $error("sequencer finished a sample too early");

endmodule

bind biquad_iir_filter_top bqf_chk #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_bqf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .sample_out_i(sample_out_o),
  .clipped_i   (clipped_o)
);
